[sv/cct_pkg.sv]
// ---------------------------------------------------------------------------
// cct_pkg: shared constants and types for the McCamy color temperature block
// Matrix coefficients, cubic constants, ratio formats and status codes.
// ---------------------------------------------------------------------------
package cct_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	// Ratio format: signed Q4.16.
	localparam int RATIO_W = 20;

	// Matrix coefficients, signed Q2.14.
	localparam logic signed [15:0] C_XR = -16'sd2340;
	localparam logic signed [15:0] C_XG = 16'sd25383;
	localparam logic signed [15:0] C_XB = -16'sd15670;
	localparam logic signed [15:0] C_YR = -16'sd5319;
	localparam logic signed [15:0] C_YG = 16'sd25860;
	localparam logic signed [15:0] C_YB = -16'sd11992;
	localparam logic signed [15:0] C_ZR = -16'sd11174;
	localparam logic signed [15:0] C_ZG = 16'sd12628;
	localparam logic signed [15:0] C_ZB = 16'sd9229;

	// Chromaticity offsets of the epicenter, Q4.16.
	localparam logic signed [20:0] XC_OFF = 21'sd21758;
	localparam logic signed [20:0] YC_OFF = 21'sd12177;

	// Cubic constants, Q.16; K3_INT is an integer.
	localparam logic signed [30:0] K3_INT = 31'sd449;
	localparam logic signed [30:0] K2 = 31'sd231014400;
	localparam logic signed [34:0] K1 = 35'sd447171789;
	localparam logic signed [36:0] K0 = 37'sd361780347;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO_IN = 2'd1,
		ST_DEGEN   = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

endpackage

[sv/cct_div.sv]
// ---------------------------------------------------------------------------
// cct_div: pipelined signed divider with saturating quotient
// One quotient bit per stage, truncation toward zero, sideband carried along.
// ---------------------------------------------------------------------------
module cct_div import cct_pkg::*; #(
	parameter int NW = 49,
	parameter int DW = 35,
	parameter int QB = RATIO_W,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [SW-1:0]        side_in,
	output logic                 out_vld,
	output logic signed [QB-1:0] quo,
	output logic                 quo_sat,
	output logic [SW-1:0]        side_out
);

	localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

	logic [NW-1:0] nmag;
	logic [DW-1:0] dmag;

	logic [CW-1:0] rem_s  [0:QB];
	logic [QB-1:0] q_s    [0:QB];
	logic [DW-1:0] dmag_s [0:QB];
	logic          neg_s  [0:QB];
	logic          ovf_s  [0:QB];
	logic [SW-1:0] side_s [0:QB];
	logic          vld_s  [0:QB];

	logic [QB-1:0] qm;
	logic          pos_sat;
	logic          neg_sat;

	assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
	assign dmag = den[DW-1] ? DW'(-den) : DW'(den);

	// The quotient magnitude overflows QB bits when the numerator reaches den << QB.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= CW'(nmag);
			q_s[0]    <= '0;
			dmag_s[0] <= dmag;
			neg_s[0]  <= num[NW-1] ^ den[DW-1];
			ovf_s[0]  <= CW'(nmag) >= (CW'(dmag) << QB);
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		logic [CW-1:0] dsh;
		logic          ge;

		assign dsh = CW'(dmag_s[k-1]) << (QB - k);
		assign ge  = rem_s[k-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_s[k-1] - dsh : rem_s[k-1];
				q_s[k]    <= q_s[k-1] | (ge ? (QB'(1) << (QB - k)) : '0);
				dmag_s[k] <= dmag_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign qm      = q_s[QB];
	assign pos_sat = ovf_s[QB] || qm[QB-1];
	assign neg_sat = ovf_s[QB] || (qm > (QB'(1) << (QB - 1)));

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_s[QB];
			if (neg_s[QB]) begin
				quo     <= neg_sat ? {1'b1, {(QB-1){1'b0}}} : QB'(-qm);
				quo_sat <= neg_sat;
			end else begin
				quo     <= pos_sat ? {1'b0, {(QB-1){1'b1}}} : qm;
				quo_sat <= pos_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[QB];
		end
	end

endmodule

[sv/rgb_to_cct_mccamy.sv]
// ---------------------------------------------------------------------------
// rgb_to_cct_mccamy: correlated color temperature and lux from one RGB word
// Fixed 3x3 matrix to XYZ, chromaticity, McCamy's n and the cubic in kelvin.
// ---------------------------------------------------------------------------
// The block takes one word of red, green and blue counts per cycle and returns
// one word of color temperature, lux and status for each, in order. It is a
// single pipeline with no feedback: a word is accepted in every cycle in which
// the output side takes or has no pending result. Between the matrix and the
// Horner stages lie two chained 20-stage restoring dividers (chromaticity,
// then McCamy's n), each with an input and an output stage. The whole
// pipeline advances together; when the output is held, every stage holds and
// nothing is lost. Only the low SAMPLE_BITS bits of each count are used. An
// all-zero word gives status 1; a zero sum or a zero n divisor gives
// temperature 0 and status 2; any clamped ratio, lux or temperature gives
// status 3. The block keeps no state across words.
module rgb_to_cct_mccamy import cct_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] color_temp,
	output logic [15:0] lux,
	output logic [1:0]  status
);

	localparam logic [15:0] SMASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

	// Global advance: every stage moves when the output register is free.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: masked input word.
	logic [15:0] r_s1, g_s1, b_s1;
	logic        v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= red & SMASK;
			g_s1 <= green & SMASK;
			b_s1 <= blue & SMASK;
		end
	end

	// Stage 2: the nine matrix products.
	logic signed [16:0] rs, gs, bs;
	logic signed [32:0] p_s2 [0:8];
	logic               zin_s2;
	logic               v_s2;

	assign rs = $signed({1'b0, r_s1});
	assign gs = $signed({1'b0, g_s1});
	assign bs = $signed({1'b0, b_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= rs * C_XR;
			p_s2[1] <= gs * C_XG;
			p_s2[2] <= bs * C_XB;
			p_s2[3] <= rs * C_YR;
			p_s2[4] <= gs * C_YG;
			p_s2[5] <= bs * C_YB;
			p_s2[6] <= rs * C_ZR;
			p_s2[7] <= gs * C_ZG;
			p_s2[8] <= bs * C_ZB;
			zin_s2  <= (r_s1 == '0) && (g_s1 == '0) && (b_s1 == '0);
		end
	end

	// Stage 3: X, Y and Z with 14 fraction bits; each fits 33 bits.
	logic signed [32:0] x_s3, y_s3, z_s3;
	logic               zin_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= p_s2[0] + p_s2[1] + p_s2[2];
			y_s3   <= p_s2[3] + p_s2[4] + p_s2[5];
			z_s3   <= p_s2[6] + p_s2[7] + p_s2[8];
			zin_s3 <= zin_s2;
		end
	end

	// Stage 4: the sum S and lux, the floor of Y clamped to 16 bits.
	logic signed [34:0] sum_c;
	logic signed [18:0] yint_c;
	logic signed [48:0] xnum_s4, ynum_s4;
	logic signed [34:0] s_s4;
	logic [15:0]        lux_s4;
	logic               luxsat_s4, zin_s4, szero_s4;
	logic               v_s4;

	assign sum_c  = 35'(x_s3) + 35'(y_s3) + 35'(z_s3);
	assign yint_c = 19'(y_s3 >>> 14);

	always_ff @(posedge clk) begin
		if (en) begin
			xnum_s4  <= {x_s3, 16'd0};
			ynum_s4  <= {y_s3, 16'd0};
			s_s4     <= sum_c;
			szero_s4 <= (sum_c == '0);
			zin_s4   <= zin_s3;
			if (yint_c < 0) begin
				lux_s4    <= '0;
				luxsat_s4 <= 1'b1;
			end else if (yint_c > 19'sd65535) begin
				lux_s4    <= 16'hFFFF;
				luxsat_s4 <= 1'b1;
			end else begin
				lux_s4    <= yint_c[15:0];
				luxsat_s4 <= 1'b0;
			end
		end
	end

	// Chromaticity xc = X/S and yc = Y/S in Q4.16.
	logic signed [RATIO_W-1:0] xc, yc;
	logic                      xc_sat, yc_sat, vx, vy;
	logic [16:0]               xside;
	logic [1:0]                yside;

	cct_div #(.NW(49), .DW(35), .QB(RATIO_W), .SW(17)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s4),
		.num      (xnum_s4),
		.den      (s_s4),
		.side_in  ({lux_s4, luxsat_s4}),
		.out_vld  (vx),
		.quo      (xc),
		.quo_sat  (xc_sat),
		.side_out (xside)
	);

	cct_div #(.NW(49), .DW(35), .QB(RATIO_W), .SW(2)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s4),
		.num      (ynum_s4),
		.den      (s_s4),
		.side_in  ({zin_s4, szero_s4}),
		.out_vld  (vy),
		.quo      (yc),
		.quo_sat  (yc_sat),
		.side_out (yside)
	);

	// Stage 5: numerator and divisor of McCamy's n.
	logic signed [20:0] dn_c;
	logic signed [36:0] nnum_s5;
	logic signed [20:0] dn_s5;
	logic [19:0]        side_s5;
	logic               v_s5;

	assign dn_c = YC_OFF - 21'(yc);

	always_ff @(posedge clk) begin
		if (en) begin
			nnum_s5 <= {21'(xc) - XC_OFF, 16'd0};
			dn_s5   <= dn_c;
			// lux, sat, all zero, zero sum, zero n divisor
			side_s5 <= {xside[16:1], xside[0] | xc_sat | yc_sat, yside, dn_c == '0};
		end
	end

	logic signed [RATIO_W-1:0] nq;
	logic                      n_sat, vn;
	logic [19:0]               nside;

	cct_div #(.NW(37), .DW(21), .QB(RATIO_W), .SW(20)) u_div_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s5),
		.num      (nnum_s5),
		.den      (dn_s5),
		.side_in  (side_s5),
		.out_vld  (vn),
		.quo      (nq),
		.quo_sat  (n_sat),
		.side_out (nside)
	);

	// Horner evaluation of the cubic; a multiply-add stage, then product and shift-add stages in turn.
	logic signed [30:0] acc1_s6;
	logic signed [50:0] prod2_s7;
	logic signed [34:0] acc2_s8;
	logic signed [54:0] prod3_s9;
	logic signed [36:0] acc3_s10;
	logic signed [RATIO_W-1:0] n_s6, n_s7, n_s8;
	logic [19:0] side_s6, side_s7, side_s8, side_s9, side_s10;
	logic v_s6, v_s7, v_s8, v_s9, v_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			acc1_s6  <= 31'(nq) * K3_INT + K2;
			n_s6     <= nq;
			side_s6  <= {nside[19:4], nside[3] | n_sat, nside[2:0]};
			prod2_s7 <= 51'(acc1_s6) * 51'(n_s6);
			n_s7     <= n_s6;
			side_s7  <= side_s6;
			acc2_s8  <= 35'(prod2_s7 >>> 16) + K1;
			n_s8     <= n_s7;
			side_s8  <= side_s7;
			prod3_s9 <= 55'(acc2_s8) * 55'(n_s8);
			side_s9  <= side_s8;
			acc3_s10 <= 37'(prod3_s9 >>> 16) + K0;
			side_s10 <= side_s9;
		end
	end

	// Stage 11: output register with clamping and status priority.
	logic signed [20:0] cint_c;
	assign cint_c = 21'(acc3_s10 >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s10[2]) begin
				color_temp <= '0;
				lux        <= '0;
				status     <= ST_ZERO_IN;
			end else if (side_s10[1] || side_s10[0]) begin
				color_temp <= '0;
				lux        <= side_s10[19:4];
				status     <= ST_DEGEN;
			end else begin
				lux <= side_s10[19:4];
				if (cint_c < 0) begin
					color_temp <= '0;
					status     <= ST_SAT;
				end else if (cint_c > 21'sd65535) begin
					color_temp <= 16'hFFFF;
					status     <= ST_SAT;
				end else begin
					color_temp <= cint_c[15:0];
					status     <= side_s10[3] ? ST_SAT : ST_OK;
				end
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= vx & vy;
			v_s6      <= vn;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			out_valid <= v_s10;
		end
	end

endmodule

[dv/rgb_to_cct_mccamy_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_cct_mccamy_chk: prediction and comparison for the CCT block
// Watches both channels, predicts each result word and compares it in order.
// ---------------------------------------------------------------------------
module rgb_to_cct_mccamy_chk import cct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] color_temp,
	input  logic [15:0] lux,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [15:0] temp;
		logic [15:0] lx;
		status_t     st;
	} cct_word_t;

	cct_word_t expected_words[$];

	localparam longint RMAX = 524287;
	localparam longint RMIN = -524288;

	function automatic longint fshift(longint v);
		return v >>> 16;
	endfunction

	function automatic longint sat_ratio(longint v, ref bit sat);
		if (v > RMAX) begin
			sat = 1;
			return RMAX;
		end
		if (v < RMIN) begin
			sat = 1;
			return RMIN;
		end
		return v;
	endfunction

	function automatic logic [15:0] clamp_u16(longint v, ref bit sat);
		if (v < 0) begin
			sat = 1;
			return 16'd0;
		end
		if (v > 65535) begin
			sat = 1;
			return 16'hFFFF;
		end
		return v[15:0];
	endfunction

	function automatic cct_word_t predict_cct(logic [15:0] rr, logic [15:0] gg, logic [15:0] bb);
		cct_word_t w;
		longint r, g, b, x, y, z, s, xc, yc, d, n, acc;
		bit sat;
		r = rr;
		g = gg;
		b = bb;
		sat = 0;
		w.temp = 0;
		w.lx = 0;
		if (r == 0 && g == 0 && b == 0) begin
			w.st = ST_ZERO_IN;
			return w;
		end
		x = -2340 * r + 25383 * g - 15670 * b;
		y = -5319 * r + 25860 * g - 11992 * b;
		z = -11174 * r + 12628 * g + 9229 * b;
		w.lx = clamp_u16(y >>> 14, sat);
		s = x + y + z;
		if (s == 0) begin
			w.st = ST_DEGEN;
			return w;
		end
		xc = sat_ratio((x * 65536) / s, sat);
		yc = sat_ratio((y * 65536) / s, sat);
		d = 12177 - yc;
		if (d == 0) begin
			w.st = ST_DEGEN;
			return w;
		end
		n = sat_ratio(((xc - 21758) * 65536) / d, sat);
		acc = 449 * 65536;
		acc = fshift(acc * n) + 3525 * 65536;
		acc = fshift(acc * n) + 447171789;
		acc = fshift(acc * n) + 361780347;
		w.temp = clamp_u16(fshift(acc), sat);
		w.st = sat ? ST_SAT : ST_OK;
		return w;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		cct_word_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(predict_cct(red, green, blue));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (color_temp !== e.temp || lux !== e.lx || status !== e.st) begin
						if (color_temp !== e.temp)
							$error("color_temp expected %0d actual %0d", e.temp, color_temp);
						if (lux !== e.lx)
							$error("lux expected %0d actual %0d", e.lx, lux);
						if (status !== e.st)
							$error("status expected %0d actual %0d", e.st, status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[dv/rgb_to_cct_mccamy_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_cct_mccamy_tb: stimulus and verdict for the CCT block
// Directed corner words, then random words under varying back pressure.
// ---------------------------------------------------------------------------
module rgb_to_cct_mccamy_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [15:0] red = 0;
	logic [15:0] green = 0;
	logic [15:0] blue = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [15:0] color_temp;
	logic [15:0] lux;
	logic [1:0]  status;
	int          fail_count;
	int          pending;

	// Idle rates in percent, changed by the stimulus process between phases.
	int send_idle = 16;
	int recv_idle = 84;
	// Long hold-off of the receiver, so the pipeline fills and stalls the input.
	bit hold_off = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	rgb_to_cct_mccamy i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.color_temp(color_temp), .lux(lux), .status(status)
	);

	rgb_to_cct_mccamy_chk i_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.color_temp(color_temp), .lux(lux), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// The receiver decides readiness for every cycle on its own.
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Offer one word and hold it until it is taken. Random idle cycles come first.
	task automatic send_word(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Random counts lean on the small and the full-scale ends now and then.
	function automatic logic [15:0] rand_count();
		case ($urandom_range(5))
			0: return 16'($urandom_range(15));
			1: return 16'hFFFF - 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_random(int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0)
				send_word(rand_count(), 0, 0);
			else
				send_word(rand_count(), rand_count(), rand_count());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Corners: all zero, single and paired full channels, all full, single ones and
		// near-balanced words that push the chromaticity and n toward their limits.
		send_word(0, 0, 0);
		send_word(16'hFFFF, 0, 0);
		send_word(0, 16'hFFFF, 0);
		send_word(0, 0, 16'hFFFF);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(1, 0, 0);
		send_word(0, 1, 0);
		send_word(0, 0, 1);
		send_word(1, 1, 1);
		send_word(16'hFFFF, 16'hFFFF, 0);
		send_word(0, 16'hFFFF, 16'hFFFF);
		send_word(16'hFFFF, 0, 16'hFFFF);
		send_word(16'h8000, 16'h8000, 16'h8000);
		send_word(16'h5555, 16'hAAAA, 16'h5555);
		send_word(16'hAAAA, 16'h5555, 16'hAAAA);
		send_word(1000, 2000, 1000);
		send_word(3000, 2500, 1500);
		send_word(100, 90, 120);
		send_word(0, 2, 3);
		send_word(7, 7, 1);
		run_random(230);
		send_idle = 84;
		recv_idle <= 16;
		run_random(230);
		send_idle = 0;
		recv_idle <= 0;
		// Hold the output for a long stretch while words keep coming.
		fork
			begin
				hold_off <= 1;
				repeat (200) @(posedge clk);
				hold_off <= 0;
			end
			run_random(240);
		join
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
